// ===== sv/pscq_pkg.sv =====
`timescale 1ns / 1ps

package pscq_pkg;

   localparam int SLOTS      = 16;
   localparam int SLOT_BYTES = 256;

   localparam int SLOT_W  = $clog2(SLOTS);
   localparam int POS_W   = $clog2(SLOT_BYTES + 1);
   localparam int COUNT_W = $clog2(SLOTS + 1);
   localparam int DEPTH   = SLOTS * SLOT_BYTES;
   localparam int ADDR_W  = $clog2(DEPTH);

   localparam logic [15:0] EMPTY_CHANNEL = 16'hffff;

   typedef enum logic [1:0] {
      ACT_PUSH    = 2'd0,
      ACT_READ    = 2'd1,
      ACT_DELETE  = 2'd2,
      ACT_RESERVE = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_TOO_LONG = 2'd1,
      ST_FULL     = 2'd2,
      ST_EMPTY    = 2'd3
   } status_type;

   typedef struct packed {
      action_type  action;
      logic [7:0]  data_byte;
      logic        last_byte;
      logic [15:0] channel_tag;
      logic [7:0]  byte_index;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [7:0]  read_byte;
      logic [8:0]  head_length;
      logic [15:0] head_channel;
      logic [4:0]  entries;
      logic        is_empty;
      logic        is_full;
   } rsp_type;

endpackage

// ===== sv/pscq_ram.sv =====
`timescale 1ns / 1ps

module pscq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/packet_slot_ring_queue_unit.sv =====
// Ring queue of packet slots. Each item is one action: push a payload byte into the tail
// slot (the last byte commits its length and channel), read one byte of the head packet,
// delete the head packet, or reserve an empty slot at the tail. Every item gives exactly
// one result in the cycle after it is accepted, carrying the status, the head packet's
// length and channel, and the occupancy with its empty and full flags. One item is taken
// per cycle; the payload memory has a registered read port. A result that is held by
// rsp_stall holds off the next item. Payload memory needs no clearing after reset, so the
// block takes items from the first cycle after reset.
`timescale 1ns / 1ps

module packet_slot_ring_queue_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  pscq_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pscq_pkg::rsp_type rsp_payload
);

   logic [pscq_pkg::SLOT_W-1:0]  tail_ff, tail_in;
   logic [pscq_pkg::SLOT_W-1:0]  head_ff, head_in;
   logic [pscq_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [pscq_pkg::POS_W-1:0]   wpos_ff, wpos_in;
   logic                         ovf_ff, ovf_in;
   logic [pscq_pkg::POS_W-1:0]   len_ff [pscq_pkg::SLOTS];
   logic [pscq_pkg::POS_W-1:0]   len_in [pscq_pkg::SLOTS];
   logic [15:0]                  chan_ff [pscq_pkg::SLOTS];
   logic [15:0]                  chan_in [pscq_pkg::SLOTS];

   logic                         rsp_valid_ff, rsp_valid_in;
   pscq_pkg::status_type         status_ff, status_in;
   logic                         rdok_ff, rdok_in;
   logic [8:0]                   hlen_ff, hlen_in;
   logic [15:0]                  hchan_ff, hchan_in;
   logic [4:0]                   entries_ff, entries_in;
   logic                         empty_ff, empty_in;
   logic                         full_ff, full_in;

   logic                         accept;
   logic                         wr_en;
   logic                         rd_en;
   logic [pscq_pkg::ADDR_W-1:0]  wr_addr;
   logic [pscq_pkg::ADDR_W-1:0]  rd_addr;
   logic [7:0]                   rd_data;
   logic                         is_full_now;
   logic                         is_empty_now;
   logic [pscq_pkg::SLOT_W-1:0]  tail_next;
   logic [pscq_pkg::SLOT_W-1:0]  head_next;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign is_full_now  = (count_ff == pscq_pkg::COUNT_W'(pscq_pkg::SLOTS));
   assign is_empty_now = (count_ff == '0);
   assign tail_next    = (tail_ff == pscq_pkg::SLOT_W'(pscq_pkg::SLOTS - 1)) ?
                         '0 : tail_ff + 1'b1;
   assign head_next    = (head_ff == pscq_pkg::SLOT_W'(pscq_pkg::SLOTS - 1)) ?
                         '0 : head_ff + 1'b1;

   assign wr_addr = pscq_pkg::ADDR_W'(tail_ff) * pscq_pkg::ADDR_W'(pscq_pkg::SLOT_BYTES)
                    + pscq_pkg::ADDR_W'(wpos_ff);
   assign rd_addr = pscq_pkg::ADDR_W'(head_ff) * pscq_pkg::ADDR_W'(pscq_pkg::SLOT_BYTES)
                    + pscq_pkg::ADDR_W'(req_payload.byte_index);

   always_comb begin
      tail_in   = tail_ff;
      head_in   = head_ff;
      count_in  = count_ff;
      wpos_in   = wpos_ff;
      ovf_in    = ovf_ff;
      len_in    = len_ff;
      chan_in   = chan_ff;
      status_in = pscq_pkg::ST_OK;
      rdok_in   = 1'b0;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      case (req_payload.action)
         pscq_pkg::ACT_PUSH: begin
            if (is_full_now) begin
               status_in = pscq_pkg::ST_FULL;
               if (req_payload.last_byte) begin
                  wpos_in = '0;
                  ovf_in  = 1'b0;
               end
            end else begin
               if (wpos_ff < pscq_pkg::POS_W'(pscq_pkg::SLOT_BYTES)) begin
                  wr_en   = accept;
                  wpos_in = wpos_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
               if (ovf_in) begin
                  status_in = pscq_pkg::ST_TOO_LONG;
                  if (req_payload.last_byte) begin
                     wpos_in = '0;
                     ovf_in  = 1'b0;
                  end
               end else if (req_payload.last_byte) begin
                  len_in[tail_ff]  = wpos_in;
                  chan_in[tail_ff] = req_payload.channel_tag;
                  tail_in          = tail_next;
                  count_in         = count_ff + 1'b1;
                  wpos_in          = '0;
               end
            end
         end
         pscq_pkg::ACT_READ: begin
            if (is_empty_now) begin
               status_in = pscq_pkg::ST_EMPTY;
            end else if (32'(req_payload.byte_index) < 32'(len_ff[head_ff]) &&
                         32'(req_payload.byte_index) < 32'(pscq_pkg::SLOT_BYTES)) begin
               rdok_in = 1'b1;
               rd_en   = accept;
            end
         end
         pscq_pkg::ACT_DELETE: begin
            if (is_empty_now) begin
               status_in = pscq_pkg::ST_EMPTY;
            end else begin
               len_in[head_ff]  = '0;
               chan_in[head_ff] = pscq_pkg::EMPTY_CHANNEL;
               head_in          = head_next;
               count_in         = count_ff - 1'b1;
            end
         end
         pscq_pkg::ACT_RESERVE: begin
            if (is_full_now) begin
               status_in = pscq_pkg::ST_FULL;
            end else begin
               len_in[tail_ff]  = '0;
               chan_in[tail_ff] = '0;
               tail_in          = tail_next;
               count_in         = count_ff + 1'b1;
               wpos_in          = '0;
               ovf_in           = 1'b0;
            end
         end
         default: begin
            status_in = pscq_pkg::ST_OK;
         end
      endcase
      hlen_in    = 9'(len_in[head_in]);
      hchan_in   = chan_in[head_in];
      entries_in = 5'(count_in);
      empty_in   = (count_in == '0);
      full_in    = (count_in == pscq_pkg::COUNT_W'(pscq_pkg::SLOTS));
   end

   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tail_ff      <= '0;
         head_ff      <= '0;
         count_ff     <= '0;
         wpos_ff      <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < pscq_pkg::SLOTS; i++) begin
            len_ff[i]  <= '0;
            chan_ff[i] <= pscq_pkg::EMPTY_CHANNEL;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            tail_ff  <= tail_in;
            head_ff  <= head_in;
            count_ff <= count_in;
            wpos_ff  <= wpos_in;
            ovf_ff   <= ovf_in;
            len_ff   <= len_in;
            chan_ff  <= chan_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff  <= status_in;
         rdok_ff    <= rdok_in;
         hlen_ff    <= hlen_in;
         hchan_ff   <= hchan_in;
         entries_ff <= entries_in;
         empty_ff   <= empty_in;
         full_ff    <= full_in;
      end
   end

   pscq_ram #(
      .WIDTH (8),
      .DEPTH (pscq_pkg::DEPTH)
   ) u_payload (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_payload.data_byte),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_payload.status       = status_ff;
   assign rsp_payload.read_byte    = rdok_ff ? rd_data : 8'd0;
   assign rsp_payload.head_length  = hlen_ff;
   assign rsp_payload.head_channel = hchan_ff;
   assign rsp_payload.entries      = entries_ff;
   assign rsp_payload.is_empty     = empty_ff;
   assign rsp_payload.is_full      = full_ff;

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= pscq_pkg::COUNT_W'(pscq_pkg::SLOTS))
      else $error("occupancy exceeds the slot count");

   assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || is_full_now) |-> (head_ff == tail_ff))
      else $error("head and tail disagree with occupancy");

   assert property (@(posedge clock) disable iff (reset)
      wpos_ff <= pscq_pkg::POS_W'(pscq_pkg::SLOT_BYTES))
      else $error("write position beyond slot size");

   assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted item produced no result");

endmodule

// ===== tb/packet_slot_ring_queue_checker.sv =====
`timescale 1ns / 1ps

module packet_slot_ring_queue_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  pscq_pkg::req_type req_payload,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  pscq_pkg::rsp_type rsp_payload,
   output int                fail_count,
   output int                pending_count,
   output int                checked_count,
   output int                too_long_count,
   output int                full_count,
   output int                empty_count
);

   import pscq_pkg::*;

   logic [7:0]         byte_mem [DEPTH];
   logic [8:0]         len_of_slot [SLOTS];
   logic [15:0]        chan_of_slot [SLOTS];
   logic [SLOT_W-1:0]  tail_idx;
   logic [SLOT_W-1:0]  head_idx;
   logic [COUNT_W-1:0] used_slots;
   logic [POS_W-1:0]   fill_pos;
   logic               too_long_seen;
   rsp_type            queue_results [$];

   function automatic logic [SLOT_W-1:0] slot_after(input logic [SLOT_W-1:0] s);
      slot_after = SLOT_W'((int'(s) + 1) % SLOTS);
   endfunction

   // Applies one item to the local copy of the queue and returns the result it gives.
   function automatic rsp_type apply_action(input req_type it);
      rsp_type r;
      r = '0;
      r.status = ST_OK;
      case (it.action)
         ACT_PUSH: begin
            if (used_slots == SLOTS) begin
               r.status = ST_FULL;
               if (it.last_byte) begin
                  fill_pos = '0;
                  too_long_seen = 1'b0;
               end
            end else begin
               if (fill_pos < SLOT_BYTES) begin
                  byte_mem[ADDR_W'(int'(tail_idx) * SLOT_BYTES + int'(fill_pos))] =
                     it.data_byte;
                  fill_pos = fill_pos + 1'b1;
               end else begin
                  too_long_seen = 1'b1;
               end
               if (too_long_seen) begin
                  r.status = ST_TOO_LONG;
                  if (it.last_byte) begin
                     fill_pos = '0;
                     too_long_seen = 1'b0;
                  end
               end else if (it.last_byte) begin
                  len_of_slot[tail_idx] = fill_pos;
                  chan_of_slot[tail_idx] = it.channel_tag;
                  tail_idx = slot_after(tail_idx);
                  used_slots = used_slots + 1'b1;
                  fill_pos = '0;
               end
            end
         end
         ACT_READ: begin
            if (used_slots == 0) begin
               r.status = ST_EMPTY;
            end else if (9'(it.byte_index) < len_of_slot[head_idx]) begin
               r.read_byte =
                  byte_mem[ADDR_W'(int'(head_idx) * SLOT_BYTES + int'(it.byte_index))];
            end
         end
         ACT_DELETE: begin
            if (used_slots == 0) begin
               r.status = ST_EMPTY;
            end else begin
               len_of_slot[head_idx] = '0;
               chan_of_slot[head_idx] = EMPTY_CHANNEL;
               head_idx = slot_after(head_idx);
               used_slots = used_slots - 1'b1;
            end
         end
         default: begin
            if (used_slots == SLOTS) begin
               r.status = ST_FULL;
            end else begin
               len_of_slot[tail_idx] = '0;
               chan_of_slot[tail_idx] = '0;
               tail_idx = slot_after(tail_idx);
               used_slots = used_slots + 1'b1;
               fill_pos = '0;
               too_long_seen = 1'b0;
            end
         end
      endcase
      r.head_length = len_of_slot[head_idx];
      r.head_channel = chan_of_slot[head_idx];
      r.entries = used_slots;
      r.is_empty = (used_slots == 0);
      r.is_full = (used_slots == SLOTS);
      return r;
   endfunction

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            len_of_slot[i] = '0;
            chan_of_slot[i] = EMPTY_CHANNEL;
         end
         tail_idx = '0;
         head_idx = '0;
         used_slots = '0;
         fill_pos = '0;
         too_long_seen = 1'b0;
         queue_results.delete();
         fail_count = 0;
         checked_count = 0;
         too_long_count = 0;
         full_count = 0;
         empty_count = 0;
      end else begin
         if (req_valid && !req_stall) begin
            queue_results.push_back(apply_action(req_payload));
         end
         if (rsp_valid && !rsp_stall) begin
            if (queue_results.size() == 0) begin
               $error("Result arrived with no item outstanding.");
               fail_count++;
            end else begin
               want = queue_results.pop_front();
               check_field("status", 16'(want.status), 16'(rsp_payload.status));
               check_field("read_byte", 16'(want.read_byte), 16'(rsp_payload.read_byte));
               check_field("head_length", 16'(want.head_length),
                           16'(rsp_payload.head_length));
               check_field("head_channel", want.head_channel, rsp_payload.head_channel);
               check_field("entries", 16'(want.entries), 16'(rsp_payload.entries));
               check_field("is_empty", 16'(want.is_empty), 16'(rsp_payload.is_empty));
               check_field("is_full", 16'(want.is_full), 16'(rsp_payload.is_full));
               checked_count++;
               if (want.status == ST_TOO_LONG) too_long_count++;
               if (want.status == ST_FULL) full_count++;
               if (want.status == ST_EMPTY) empty_count++;
            end
         end
      end
      pending_count = queue_results.size();
   end

endmodule

// ===== tb/packet_slot_ring_queue_unit_tb.sv =====
`timescale 1ns / 1ps

module packet_slot_ring_queue_unit_tb;

   import pscq_pkg::*;

   typedef enum int {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_style_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_payload;

   int fail_count;
   int pending_count;
   int checked_count;
   int too_long_count;
   int full_count;
   int empty_count;

   int items_sent = 0;
   int burst_left = 0;
   int long_packets = 0;

   stall_style_type stall_style = STALL_NONE;
   int              stall_left = 0;
   int              cycle_num = 0;

   packet_slot_ring_queue_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   packet_slot_ring_queue_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_payload    (rsp_payload),
      .fail_count     (fail_count),
      .pending_count  (pending_count),
      .checked_count  (checked_count),
      .too_long_count (too_long_count),
      .full_count     (full_count),
      .empty_count    (empty_count)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_style = stall_style_type'($urandom_range(0, 3));
         stall_left = $urandom_range(20, 200);
      end
      stall_left--;
      cycle_num++;
      case (stall_style)
         STALL_NONE:     rsp_stall <= 1'b0;
         STALL_LIGHT:    rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY:    rsp_stall <= ($urandom_range(0, 9) < 7);
         default:        rsp_stall <= (cycle_num % 3 == 0);
      endcase
   end

   // Called at a rising edge; returns at the rising edge where the item is taken.
   task automatic send_item(input action_type act, input logic [7:0] data,
                            input logic last, input logic [15:0] chan,
                            input logic [7:0] idx);
      req_type it;
      int      gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 120)
                                                  : $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      it.action = act;
      it.data_byte = data;
      it.last_byte = last;
      it.channel_tag = chan;
      it.byte_index = idx;
      req_valid <= 1'b1;
      req_payload <= it;
      do @(negedge clock); while (req_stall);
      @(posedge clock);
      items_sent++;
      burst_left--;
   endtask

   function automatic logic [7:0] any_byte();
      any_byte = 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [15:0] any_chan();
      any_chan = 16'($urandom_range(0, 65535));
   endfunction

   task automatic push_packet(input int n, input logic [15:0] chan, input logic [7:0] first);
      for (int i = 0; i < n; i++) begin
         send_item(ACT_PUSH, (i == 0) ? first : any_byte(), i == n - 1,
                   (i == n - 1) ? chan : any_chan(), any_byte());
      end
   endtask

   task automatic plain_item(input action_type act, input logic [7:0] idx);
      send_item(act, any_byte(), 1'($urandom_range(0, 1)), any_chan(), idx);
   endtask

   task automatic random_sequence(input int seq_num);
      int pick;
      int n;
      pick = $urandom_range(0, 99);
      if (seq_num % 60 == 30) begin
         // Lengths at and just past the slot size.
         push_packet(SLOT_BYTES + (long_packets % 3), any_chan(), any_byte());
         long_packets++;
         repeat ($urandom_range(2, 5)) plain_item(ACT_READ, any_byte());
      end else if (pick < 35) begin
         n = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 32) : $urandom_range(1, 8);
         push_packet(n, any_chan(), any_byte());
      end else if (pick < 55) begin
         repeat ($urandom_range(1, 4)) begin
            plain_item(ACT_READ, ($urandom_range(0, 4) == 0) ? any_byte()
                                                           : 8'($urandom_range(0, 9)));
         end
      end else if (pick < 70) begin
         repeat ($urandom_range(1, 3)) plain_item(ACT_DELETE, any_byte());
      end else if (pick < 78) begin
         plain_item(ACT_RESERVE, any_byte());
      end else if (pick < 84) begin
         repeat ($urandom_range(10, 18)) plain_item(ACT_RESERVE, any_byte());
         push_packet($urandom_range(1, 3), any_chan(), any_byte());
         plain_item(ACT_RESERVE, any_byte());
      end else if (pick < 90) begin
         repeat ($urandom_range(8, 18)) plain_item(ACT_DELETE, any_byte());
      end else if (pick < 95) begin
         n = $urandom_range(1, 5);
         for (int i = 0; i < n; i++) begin
            send_item(ACT_PUSH, any_byte(), 1'b0, any_chan(), any_byte());
         end
         if ($urandom_range(0, 1) == 0) begin
            plain_item(ACT_RESERVE, any_byte());
         end else begin
            plain_item(action_type'($urandom_range(1, 2)), any_byte());
            push_packet($urandom_range(1, 3), any_chan(), any_byte());
         end
      end else begin
         repeat ($urandom_range(1, 4)) plain_item(action_type'($urandom_range(0, 3)),
                                                  any_byte());
      end
   endtask

   initial begin
      int seq_num;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_item(ACT_READ, 8'h00, 1'b0, 16'h0000, 8'h00);
      send_item(ACT_DELETE, 8'hff, 1'b1, 16'hffff, 8'hff);
      send_item(ACT_PUSH, 8'h00, 1'b0, 16'hffff, 8'hff);
      send_item(ACT_PUSH, 8'hff, 1'b0, 16'h1234, 8'h00);
      send_item(ACT_PUSH, 8'ha5, 1'b1, 16'h0000, 8'h00);
      send_item(ACT_READ, 8'h00, 1'b0, 16'h0000, 8'd0);
      send_item(ACT_READ, 8'h00, 1'b0, 16'h0000, 8'd1);
      send_item(ACT_READ, 8'h00, 1'b0, 16'h0000, 8'd2);
      send_item(ACT_READ, 8'h00, 1'b0, 16'h0000, 8'd3);
      send_item(ACT_PUSH, 8'h5a, 1'b1, 16'hffff, 8'h00);
      send_item(ACT_RESERVE, 8'h00, 1'b0, 16'hffff, 8'h00);
      send_item(ACT_DELETE, 8'h00, 1'b0, 16'h0000, 8'h00);
      send_item(ACT_READ, 8'h00, 1'b0, 16'h0000, 8'd255);
      send_item(ACT_READ, 8'h00, 1'b0, 16'h0000, 8'd0);
      send_item(ACT_PUSH, 8'h11, 1'b0, 16'h00ff, 8'h00);
      send_item(ACT_PUSH, 8'h22, 1'b0, 16'hff00, 8'h00);
      send_item(ACT_RESERVE, 8'h00, 1'b1, 16'h5555, 8'h00);
      send_item(ACT_DELETE, 8'h00, 1'b0, 16'h0000, 8'h00);
      send_item(ACT_READ, 8'h00, 1'b0, 16'h0000, 8'd0);
      send_item(ACT_DELETE, 8'h00, 1'b0, 16'h0000, 8'h00);
      send_item(ACT_DELETE, 8'h00, 1'b0, 16'h0000, 8'h00);
      send_item(ACT_DELETE, 8'h00, 1'b0, 16'h0000, 8'h00);

      seq_num = 0;
      while (items_sent < 900) begin
         random_sequence(seq_num);
         seq_num++;
      end

      req_valid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
      repeat (8) @(posedge clock);
      $display("Run covered %0d items, %0d results checked, %0d long packets.",
               items_sent, checked_count, long_packets);
      $display("Statuses seen: %0d too long, %0d full, %0d empty.",
               too_long_count, full_count, empty_count);
      if (fail_count == 0) begin
         $display("packet_slot_ring_queue_unit test passed");
      end else begin
         $display("packet_slot_ring_queue_unit test failed");
      end
      $finish;
   end

   initial begin
      #10ms;
      $display("packet_slot_ring_queue_unit test failed");
      $finish;
   end

endmodule
